/* rtl/ltde_pkg.sv */
// Package for the local-time-to-epoch converter.
// Holds field widths, calendar constants, the rule layout, register indexes
// and the small arithmetic helpers shared by the pipeline modules.
package ltde_pkg;

   // Field widths of the ports.
   localparam int unsigned YEAR_W     = 14;
   localparam int unsigned MONTH_W    = 4;
   localparam int unsigned DAY_W      = 5;
   localparam int unsigned HOUR_W     = 5;
   localparam int unsigned MIN_W      = 6;
   localparam int unsigned SEC_W      = 6;
   localparam int unsigned OFF_W      = 17;
   localparam int unsigned RULE_W     = 15;
   localparam int unsigned EPOCH_W    = 39;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 17;

   // Internal widths.
   // Shifted year (year + 400, minus one for January and February).
   localparam int unsigned YADJ_W  = 15;
   // Day count biased so that it never goes negative.
   localparam int unsigned DAYS_W  = 23;
   // Day of year offset of the first of a month, March based.
   localparam int unsigned MBASE_W = 9;
   // Seconds within a day, including out-of-range hour, minute and second.
   localparam int unsigned TOD_W   = 17;
   // Biased naive seconds.
   localparam int unsigned SECS_W  = 40;
   // Day of month of a transition, signed (weeks 0 and 6..7 leave the month).
   localparam int unsigned DOM_W   = 8;

   // Calendar constants.
   localparam int unsigned YEAR_BIAS     = 400;
   localparam int unsigned DAYS_PER_YEAR = 365;
   localparam int unsigned SECS_PER_DAY  = 86400;
   localparam int unsigned SECS_PER_HOUR = 3600;
   localparam int unsigned SECS_PER_MIN  = 60;
   localparam int unsigned DAYS_PER_WEEK = 7;

   // Biased day count P satisfies days_since_1970 = P + day - 865566, and
   // the naive seconds carry the same bias times one day.
   localparam logic [SECS_W-1:0] EPOCH_BIAS = 40'd74784902400;

   // Weekday of a biased day count: (P + day + 2) mod 7, 0 = Sunday.
   localparam logic [DAYS_W-1:0] DOW_BIAS = 23'd2;

   // Division by 25 through a reciprocal: exact for inputs below 4681.
   localparam int unsigned RECIP25   = 2622;
   localparam int unsigned DIV_SHIFT = 16;
   localparam int unsigned DIV_IN_W  = 13;
   localparam int unsigned DIV_OUT_W = 8;

   // Month numbers that matter to the arithmetic.
   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   // Rule week code for the last occurrence in the month.
   localparam logic [2:0] WEEK_LAST = 3'd5;
   // Weekday code that folds onto Sunday.
   localparam logic [2:0] WEEKDAY_ALIAS_SUN = 3'd7;

   // Pipeline stages, in order.
   localparam int unsigned NUM_STAGES  = 8;
   localparam int unsigned STG_YEAR    = 0;
   localparam int unsigned STG_DAYS    = 1;
   localparam int unsigned STG_WEEKDAY = 2;
   localparam int unsigned STG_TRANS   = 3;
   localparam int unsigned STG_MUL     = 4;
   localparam int unsigned STG_SUM     = 5;
   localparam int unsigned STG_CMP     = 6;
   localparam int unsigned STG_OUT     = 7;

   // Load enable of each pipeline stage.
   typedef logic [NUM_STAGES-1:0] stage_en_type;

   // Transition rule as packed in its register.
   typedef struct packed {
      logic [4:0] hour;
      logic [2:0] weekday;
      logic [2:0] week;
      logic [3:0] month;
   } rule_type;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STD_OFFSET = 3'd0,
      CSR_DST_ENABLE = 3'd1,
      CSR_DST_OFFSET = 3'd2,
      CSR_DST_START  = 3'd3,
      CSR_DST_END    = 3'd4
   } csr_index_type;

   // Reset values of the configuration registers.
   localparam logic signed [OFF_W-1:0] STD_OFFSET_RST = -17'sd18000;
   localparam logic signed [OFF_W-1:0] DST_OFFSET_RST = -17'sd14400;
   localparam logic                    DST_ENABLE_RST = 1'b1;
   localparam logic [RULE_W-1:0]       DST_START_RST  = 15'd2083;
   localparam logic [RULE_W-1:0]       DST_END_RST    = 15'd2075;

   // Floor of x / 25 for x below 4681.
   function automatic logic [DIV_OUT_W-1:0] div25(input logic [DIV_IN_W-1:0] x);
      logic [DIV_IN_W+11:0] prod;
      prod = (DIV_IN_W+12)'(x) * (DIV_IN_W+12)'(RECIP25);
      return prod[DIV_SHIFT +: DIV_OUT_W];
   endfunction

   // Days from March 1 to the first of month m, months 0..2 and 13..15
   // continue the March-based count as the day formula does.
   function automatic logic [MBASE_W-1:0] month_base(input logic [MONTH_W-1:0] m);
      logic [MBASE_W-1:0] v;
      unique case (m)
         4'd0:  v = 9'd275;
         4'd1:  v = 9'd306;
         4'd2:  v = 9'd337;
         4'd3:  v = 9'd0;
         4'd4:  v = 9'd31;
         4'd5:  v = 9'd61;
         4'd6:  v = 9'd92;
         4'd7:  v = 9'd122;
         4'd8:  v = 9'd153;
         4'd9:  v = 9'd184;
         4'd10: v = 9'd214;
         4'd11: v = 9'd245;
         4'd12: v = 9'd275;
         4'd13: v = 9'd306;
         4'd14: v = 9'd337;
         4'd15: v = 9'd367;
      endcase
      return v;
   endfunction

   // Length of a month; a month number outside 1..12 counts as 31 days.
   function automatic logic [DAY_W-1:0] month_days(input logic leap,
                                                    input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] v;
      unique case (m)
         4'd2:                      v = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   v = 5'd30;
         default:                   v = 5'd31;
      endcase
      return v;
   endfunction

   // x mod 7 for a 24-bit value: octal digits add up because 8 = 1 mod 7.
   function automatic logic [2:0] mod7(input logic [23:0] x);
      logic [5:0] digit_sum;
      logic [3:0] fold;
      logic [2:0] v;
      digit_sum = '0;
      for (int k = 0; k < 8; k++) begin
         digit_sum = digit_sum + 6'(x[3*k +: 3]);
      end
      fold = 4'(digit_sum[5:3]) + 4'(digit_sum[2:0]);
      if (fold >= 4'd14) begin
         v = 3'(fold - 4'd14);
      end else if (fold >= 4'd7) begin
         v = 3'(fold - 4'd7);
      end else begin
         v = 3'(fold);
      end
      return v;
   endfunction

   // Reduce a value in 0..13 modulo 7.
   function automatic logic [2:0] wrap7(input logic [3:0] x);
      logic [2:0] v;
      if (x >= 4'd7) begin
         v = 3'(x - 4'd7);
      end else begin
         v = 3'(x);
      end
      return v;
   endfunction

endpackage

/* rtl/ltde_day_base.sv */
// Two-stage day counter: biased day number of day zero of a given month.
// Depends on ltde_pkg for widths, the divide-by-25 helper and the month table.
module ltde_day_base
   import ltde_pkg::*;
(
   input  logic                clock,
   input  stage_en_type        stage_en,
   input  logic [YEAR_W-1:0]   year,
   input  logic [MONTH_W-1:0]  month,
   output logic [DAYS_W-1:0]   days_base
);

   logic [YADJ_W-1:0]    year_adj;
   logic [YADJ_W-1:0]    year_adj_ff;
   logic [DIV_OUT_W-1:0] cent_ff;
   logic [DIV_OUT_W-1:0] cent_in;
   logic [DIV_OUT_W-1:0] quad_cent_ff;
   logic [DIV_OUT_W-1:0] quad_cent_in;
   logic [MBASE_W-1:0]   mbase_ff;
   logic [DAYS_W-1:0]    days_base_ff;
   logic [DAYS_W-1:0]    days_base_in;

   // January and February belong to the previous March-based year; the
   // year is lifted by 400 so that year zero stays non-negative.
   always_comb begin
      if (month <= MONTH_FEB) begin
         year_adj = YADJ_W'(year) + YADJ_W'(YEAR_BIAS) - YADJ_W'(1);
      end else begin
         year_adj = YADJ_W'(year) + YADJ_W'(YEAR_BIAS);
      end
      cent_in      = div25(DIV_IN_W'(year_adj[YADJ_W-1:2]));
      quad_cent_in = div25(DIV_IN_W'(year_adj[YADJ_W-1:4]));
   end

   always_ff @(posedge clock) begin
      if (stage_en[STG_YEAR]) begin
         year_adj_ff  <= year_adj;
         cent_ff      <= cent_in;
         quad_cent_ff <= quad_cent_in;
         mbase_ff     <= month_base(month);
      end
   end

   // Whole years, leap days and the month offset.
   assign days_base_in = DAYS_W'(year_adj_ff) * DAYS_W'(DAYS_PER_YEAR)
                       + DAYS_W'(year_adj_ff[YADJ_W-1:2])
                       - DAYS_W'(cent_ff)
                       + DAYS_W'(quad_cent_ff)
                       + DAYS_W'(mbase_ff);

   always_ff @(posedge clock) begin
      if (stage_en[STG_DAYS]) begin
         days_base_ff <= days_base_in;
      end
   end

   assign days_base = days_base_ff;

endmodule

/* rtl/ltde_rule_day.sv */
// Two-stage resolver of an nth-weekday rule to a biased day number.
// Depends on ltde_pkg for the rule layout, month lengths and modulo-7 helpers.
module ltde_rule_day
   import ltde_pkg::*;
(
   input  logic               clock,
   input  stage_en_type       stage_en,
   input  logic [DAYS_W-1:0]  days_base,
   input  logic               leap,
   input  rule_type           rule,
   output logic [DAYS_W-1:0]  trans_days
);

   logic [DAY_W-1:0]        month_end;
   logic [DAY_W-1:0]        anchor_in;
   logic [DAYS_W-1:0]       anchor_days;
   logic [DAYS_W-1:0]       base_ff;
   logic [DAY_W-1:0]        anchor_ff;
   logic [2:0]              dow_ff;
   logic [2:0]              dow_in;
   logic [2:0]              weekday;
   logic [2:0]              step;
   logic signed [DOM_W-1:0] dom;
   logic [DAYS_W-1:0]       trans_in;
   logic [DAYS_W-1:0]       trans_ff;

   // The anchor is the last day of the month for the last-weekday rule and
   // the first day otherwise; find the weekday of the anchor.
   always_comb begin
      month_end   = month_days(leap, rule.month);
      anchor_in   = (rule.week == WEEK_LAST) ? month_end : DAY_W'(1);
      anchor_days = days_base + DAYS_W'(anchor_in) + DOW_BIAS;
      dow_in      = mod7(24'(anchor_days));
   end

   always_ff @(posedge clock) begin
      if (stage_en[STG_WEEKDAY]) begin
         base_ff   <= days_base;
         anchor_ff <= anchor_in;
         dow_ff    <= dow_in;
      end
   end

   // Step back to the wanted weekday from the last day, or forward from the
   // first day and then on by whole weeks.
   always_comb begin
      weekday = (rule.weekday == WEEKDAY_ALIAS_SUN) ? 3'd0 : rule.weekday;
      if (rule.week == WEEK_LAST) begin
         step = wrap7(4'(dow_ff) + 4'(DAYS_PER_WEEK) - 4'(weekday));
         dom  = $signed(DOM_W'(anchor_ff)) - $signed(DOM_W'(step));
      end else begin
         step = wrap7(4'(weekday) + 4'(DAYS_PER_WEEK) - 4'(dow_ff));
         dom  = $signed(DOM_W'(anchor_ff)) + $signed(DOM_W'(step))
              + $signed(DOM_W'(rule.week)) * $signed(DOM_W'(DAYS_PER_WEEK))
              - $signed(DOM_W'(DAYS_PER_WEEK));
      end
      trans_in = base_ff + {{(DAYS_W-DOM_W){dom[DOM_W-1]}}, dom};
   end

   always_ff @(posedge clock) begin
      if (stage_en[STG_TRANS]) begin
         trans_ff <= trans_in;
      end
   end

   assign trans_days = trans_ff;

endmodule

/* rtl/ltde_epoch_calc.sv */
// Four-stage back end: day numbers to seconds, daylight window test and
// offset removal. Depends on ltde_pkg for widths and the epoch bias.
module ltde_epoch_calc
   import ltde_pkg::*;
(
   input  logic                       clock,
   input  stage_en_type               stage_en,
   input  logic [DAYS_W-1:0]          local_days,
   input  logic [TOD_W-1:0]           tod,
   input  logic [DAYS_W-1:0]          start_days,
   input  logic [DAYS_W-1:0]          end_days,
   input  logic [HOUR_W-1:0]          start_hour,
   input  logic [HOUR_W-1:0]          end_hour,
   input  logic                       dst_enable,
   input  logic signed [OFF_W-1:0]    std_offset,
   input  logic signed [OFF_W-1:0]    dst_offset,
   output logic signed [EPOCH_W-1:0]  epoch_seconds
);

   logic [SECS_W-1:0]        local_sec_ff;
   logic [SECS_W-1:0]        start_sec_ff;
   logic [SECS_W-1:0]        end_sec_ff;
   logic [TOD_W-1:0]         tod_ff;
   logic [SECS_W-1:0]        naive_ff;
   logic [SECS_W-1:0]        naive_in;
   logic [SECS_W-1:0]        start_ff;
   logic [SECS_W-1:0]        start_in;
   logic [SECS_W-1:0]        end_ff;
   logic [SECS_W-1:0]        end_in;
   logic                     use_dst;
   logic signed [OFF_W-1:0]  offset_ff;
   logic [EPOCH_W-1:0]       unbiased_ff;
   logic [EPOCH_W-1:0]       epoch_ff;
   logic [EPOCH_W-1:0]       epoch_in;

   // Whole days to seconds, one multiplier per day number.
   always_ff @(posedge clock) begin
      if (stage_en[STG_MUL]) begin
         local_sec_ff <= SECS_W'(local_days) * SECS_W'(SECS_PER_DAY);
         start_sec_ff <= SECS_W'(start_days) * SECS_W'(SECS_PER_DAY);
         end_sec_ff   <= SECS_W'(end_days) * SECS_W'(SECS_PER_DAY);
         tod_ff       <= tod;
      end
   end

   // Add the time of day and the transition hours.
   always_comb begin
      naive_in = local_sec_ff + SECS_W'(tod_ff);
      start_in = start_sec_ff + SECS_W'(start_hour) * SECS_W'(SECS_PER_HOUR);
      end_in   = end_sec_ff + SECS_W'(end_hour) * SECS_W'(SECS_PER_HOUR);
   end

   always_ff @(posedge clock) begin
      if (stage_en[STG_SUM]) begin
         naive_ff <= naive_in;
         start_ff <= start_in;
         end_ff   <= end_in;
      end
   end

   // Daylight time applies on the half-open window from start to end.
   assign use_dst = dst_enable && (naive_ff >= start_ff) && (naive_ff < end_ff);

   always_ff @(posedge clock) begin
      if (stage_en[STG_CMP]) begin
         offset_ff   <= use_dst ? dst_offset : std_offset;
         unbiased_ff <= naive_ff[EPOCH_W-1:0] - EPOCH_BIAS[EPOCH_W-1:0];
      end
   end

   // Remove the offset; the result wraps to the output width.
   assign epoch_in = unbiased_ff - {{(EPOCH_W-OFF_W){offset_ff[OFF_W-1]}}, offset_ff};

   always_ff @(posedge clock) begin
      if (stage_en[STG_OUT]) begin
         epoch_ff <= epoch_in;
      end
   end

   assign epoch_seconds = $signed(epoch_ff);

endmodule

/* rtl/local_time_to_epoch_dst_top.sv */
// Top level of the local-time-to-epoch converter with daylight rules.
// Depends on ltde_pkg, ltde_day_base, ltde_rule_day and ltde_epoch_calc.
//
// Converts a local date and time into signed Unix epoch seconds, using the
// standard offset or, inside the configured daylight window of that year,
// the daylight offset. The block is an eight-stage pipeline: one word enters
// per cycle while the output is not stalled, and its result is registered in
// the last stage. Every stage holds its own valid bit and loads whenever it
// is empty or its successor moves, so a stalled output only backs up the
// pipeline as far as it is full and bubbles are squeezed out. The stages are
// two day-number stages, two rule stages and four seconds stages (multiply,
// add, compare, offset). Configuration registers are written through the csr
// port with no wait; the stages read them as a word passes, so write them
// only while no word is in flight. No word is taken while reset is high.
module local_time_to_epoch_dst_top
   import ltde_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // Request channel
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [YEAR_W-1:0]          req_year,
   input  logic [MONTH_W-1:0]         req_month,
   input  logic [DAY_W-1:0]           req_day,
   input  logic [HOUR_W-1:0]          req_hour,
   input  logic [MIN_W-1:0]           req_minute,
   input  logic [SEC_W-1:0]           req_second,
   // Response channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [EPOCH_W-1:0]  rsp_epoch_seconds,
   // Configuration port
   input  logic                       csr_wr_en,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   logic signed [OFF_W-1:0] std_offset_ff;
   logic signed [OFF_W-1:0] dst_offset_ff;
   logic                    dst_enable_ff;
   rule_type                start_rule_ff;
   rule_type                end_rule_ff;

   logic [NUM_STAGES-1:0]   valid_ff;
   stage_en_type            stage_en;

   logic [YEAR_W-1:0]       year_ff;
   logic [DIV_OUT_W-1:0]    cent_ff;
   logic [DIV_OUT_W-1:0]    quad_cent_ff;
   logic [DAY_W-1:0]        day1_ff;
   logic [TOD_W-1:0]        tod1_ff;
   logic [TOD_W-1:0]        tod_in;
   logic                    leap_ff;
   logic                    leap_in;
   logic [DIV_IN_W-1:0]     cent_x25;
   logic [DIV_IN_W-1:0]     quad_cent_x25;
   logic [DAY_W-1:0]        day2_ff;
   logic [TOD_W-1:0]        tod2_ff;
   logic [DAYS_W-1:0]       local_days3_ff;
   logic [TOD_W-1:0]        tod3_ff;
   logic [DAYS_W-1:0]       local_days4_ff;
   logic [TOD_W-1:0]        tod4_ff;

   logic [DAYS_W-1:0]       local_base;
   logic [DAYS_W-1:0]       start_base;
   logic [DAYS_W-1:0]       end_base;
   logic [DAYS_W-1:0]       start_days;
   logic [DAYS_W-1:0]       end_days;

   // Configuration registers; writes to unused indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         std_offset_ff <= STD_OFFSET_RST;
         dst_enable_ff <= DST_ENABLE_RST;
         dst_offset_ff <= DST_OFFSET_RST;
         start_rule_ff <= rule_type'(DST_START_RST);
         end_rule_ff   <= rule_type'(DST_END_RST);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_STD_OFFSET: std_offset_ff <= $signed(csr_wdata[OFF_W-1:0]);
            CSR_DST_ENABLE: dst_enable_ff <= csr_wdata[0];
            CSR_DST_OFFSET: dst_offset_ff <= $signed(csr_wdata[OFF_W-1:0]);
            CSR_DST_START:  start_rule_ff <= rule_type'(csr_wdata[RULE_W-1:0]);
            CSR_DST_END:    end_rule_ff   <= rule_type'(csr_wdata[RULE_W-1:0]);
            default: begin
            end
         endcase
      end
   end

   // A stage loads when it is empty or the stage after it moves on.
   always_comb begin
      stage_en[STG_OUT] = !valid_ff[STG_OUT] || rsp_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_en[STG_YEAR]) begin
            valid_ff[STG_YEAR] <= req_valid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // The input is closed while reset is held, since a word offered then is dropped.
   assign req_ready = stage_en[STG_YEAR] && !reset;
   assign rsp_valid = valid_ff[STG_OUT];

   // First stage: time of day and the century quotients for the leap test.
   assign tod_in = TOD_W'(req_hour) * TOD_W'(SECS_PER_HOUR)
                 + TOD_W'(req_minute) * TOD_W'(SECS_PER_MIN)
                 + TOD_W'(req_second);

   always_ff @(posedge clock) begin
      if (stage_en[STG_YEAR]) begin
         year_ff      <= req_year;
         cent_ff      <= div25(DIV_IN_W'(req_year[YEAR_W-1:2]));
         quad_cent_ff <= div25(DIV_IN_W'(req_year[YEAR_W-1:4]));
         day1_ff      <= req_day;
         tod1_ff      <= tod_in;
      end
   end

   // Second stage: Gregorian leap year of the input year.
   always_comb begin
      cent_x25      = DIV_IN_W'(cent_ff) * DIV_IN_W'(25);
      quad_cent_x25 = DIV_IN_W'(quad_cent_ff) * DIV_IN_W'(25);
      leap_in = (year_ff[1:0] == 2'd0)
             && ((DIV_IN_W'(year_ff[YEAR_W-1:2]) != cent_x25)
              || ((year_ff[3:2] == 2'd0)
               && (DIV_IN_W'(year_ff[YEAR_W-1:4]) == quad_cent_x25)));
   end

   always_ff @(posedge clock) begin
      if (stage_en[STG_DAYS]) begin
         leap_ff <= leap_in;
         day2_ff <= day1_ff;
         tod2_ff <= tod1_ff;
      end
   end

   // Day numbers of the input date and of the two rule months.
   ltde_day_base u_local_base (
      .clock     (clock),
      .stage_en  (stage_en),
      .year      (req_year),
      .month     (req_month),
      .days_base (local_base)
   );

   ltde_day_base u_start_base (
      .clock     (clock),
      .stage_en  (stage_en),
      .year      (req_year),
      .month     (start_rule_ff.month),
      .days_base (start_base)
   );

   ltde_day_base u_end_base (
      .clock     (clock),
      .stage_en  (stage_en),
      .year      (req_year),
      .month     (end_rule_ff.month),
      .days_base (end_base)
   );

   // Input date day number, carried alongside the rule stages.
   always_ff @(posedge clock) begin
      if (stage_en[STG_WEEKDAY]) begin
         local_days3_ff <= local_base + DAYS_W'(day2_ff);
         tod3_ff        <= tod2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[STG_TRANS]) begin
         local_days4_ff <= local_days3_ff;
         tod4_ff        <= tod3_ff;
      end
   end

   // Transition days of the year.
   ltde_rule_day u_start_day (
      .clock      (clock),
      .stage_en   (stage_en),
      .days_base  (start_base),
      .leap       (leap_ff),
      .rule       (start_rule_ff),
      .trans_days (start_days)
   );

   ltde_rule_day u_end_day (
      .clock      (clock),
      .stage_en   (stage_en),
      .days_base  (end_base),
      .leap       (leap_ff),
      .rule       (end_rule_ff),
      .trans_days (end_days)
   );

   // Seconds, window test and offset.
   ltde_epoch_calc u_epoch_calc (
      .clock         (clock),
      .stage_en      (stage_en),
      .local_days    (local_days4_ff),
      .tod           (tod4_ff),
      .start_days    (start_days),
      .end_days      (end_days),
      .start_hour    (start_rule_ff.hour),
      .end_hour      (end_rule_ff.hour),
      .dst_enable    (dst_enable_ff),
      .std_offset    (std_offset_ff),
      .dst_offset    (dst_offset_ff),
      .epoch_seconds (rsp_epoch_seconds)
   );

endmodule
